/* rtl/core/tws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg - tile write snoop hasher package
// Field widths, stream packing, hash constants, sequencer codes and types.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int OFFSET_W   = 13;
	localparam int BYTE_W     = 8;
	localparam int TILE_W     = 9;
	localparam int LANE_W     = 4;
	localparam int TILE_BYTES = 16;
	localparam int HASH_W     = 64;
	localparam int HALF_W     = 32;

	localparam int IN_FIELDS_W  = OFFSET_W + BYTE_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = TILE_W + HASH_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [HASH_W-1:0] HASH_MUL   = 64'h9ddfea08eb382d69;
	localparam int                HASH_SHIFT = 47;
	localparam int                ROR_SHIFT  = 16;
	localparam logic [HASH_W-1:0] B_OFFSET   = 64'd16;

	localparam logic [1:0] PH_LO    = 2'd0;
	localparam logic [1:0] PH_HI    = 2'd1;
	localparam logic [1:0] PH_CROSS = 2'd2;

	localparam logic [1:0] RND_FIRST  = 2'd0;
	localparam logic [1:0] RND_SECOND = 2'd1;
	localparam logic [1:0] RND_FINAL  = 2'd2;

	typedef logic [TILE_BYTES-1:0][BYTE_W-1:0] tws_row_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DONE
	} tws_state_t;

endpackage

/* rtl/core/tile_write_snoop_hasher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_write_snoop_hasher - video memory tile mirror and tile hasher
// Mirrors in-range byte writes into a tile memory and, with auto_dump set, emits
// the hash of a tile when the write stream leaves it.
// ----------------------------------------------------------------------------
// Sequence: a write that leaves a tile has its row hashed through ST_LOAD, ST_MUL
//   and ST_DONE onto m_axis; a write that emits nothing completes in its own cycle.
// Throughput: one non-emitting write per cycle while idle; an emitting write holds
//   the input low until the hash sequence returns to ST_IDLE, so no new write is
//   taken while a tile is hashed; one shared 32x32 multiplier builds each of the
//   three 64-bit products from three partial products; a stalled result output extends the hold.
// Reset: arst_n clears control state, then a clearing pass zeroes the mirror
//   one tile per cycle (TILE_COUNT tiles, 384 by default) with s_axis_tready
//   low; configuration writes are taken throughout.
module tile_write_snoop_hasher #(
	parameter int TILE_COUNT = 384
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data,       // auto_dump
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tws_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // vram_offset, write_data
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [tws_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // tile_index, tile_hash
);
	import tws_pkg::*;

	localparam int ROW_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
	localparam logic [ROW_W-1:0]  CLR_LAST = ROW_W'(TILE_COUNT - 1);
	localparam logic [TILE_W:0]   TILE_LIM = (TILE_W + 1)'(TILE_COUNT);
	localparam logic [HALF_W-1:0] MUL_LO   = HASH_MUL[HALF_W-1:0];
	localparam logic [HALF_W-1:0] MUL_HI   = HASH_MUL[HASH_W-1:HALF_W];

	tws_row_t mem_q [TILE_COUNT];
	tws_row_t rd_row_q;

	tws_state_t state_q, state_d;
	logic [ROW_W-1:0]  clr_q;
	logic [1:0]        ph_q, rnd_q;
	logic              auto_dump_q;
	logic              last_vld_q;
	logic [TILE_W-1:0] last_tile_q;
	logic [TILE_W-1:0] pend_tile_q;
	logic              out_vld_q;
	logic [TILE_W-1:0] out_tile_q;
	logic [HASH_W-1:0] out_hash_q;

	logic [HASH_W-1:0] opnd_q, v_q, b_q, prod_lo_q, hash_q;
	logic [HALF_W-1:0] hi_acc_q;

	logic [OFFSET_W-1:0] in_off;
	logic [BYTE_W-1:0]   in_byte;
	logic [TILE_W-1:0]   in_tile;
	logic [LANE_W-1:0]   in_lane;
	logic                in_bound, emit, s_fire, out_free, in_rdy;

	logic [HASH_W-1:0] w_a, w_b, b_plus, v_rot;
	logic [HALF_W-1:0] mul_a, mul_b;
	logic [HASH_W-1:0] mul_p, prod_full, prod_mix;

	assign in_off   = s_axis_tdata[OFFSET_W-1:0];
	assign in_byte  = s_axis_tdata[IN_FIELDS_W-1:OFFSET_W];
	assign in_tile  = in_off[OFFSET_W-1:LANE_W];
	assign in_lane  = in_off[LANE_W-1:0];
	assign in_bound = {1'b0, in_tile} < TILE_LIM;
	assign emit     = in_bound && last_vld_q && (last_tile_q != in_tile) && auto_dump_q;
	assign s_fire   = s_axis_tvalid && in_rdy;
	assign out_free = !out_vld_q || m_axis_tready;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = in_rdy;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_hash_q, out_tile_q};

	assign w_a    = rd_row_q[7:0];
	assign w_b    = rd_row_q[15:8];
	assign b_plus = w_b + B_OFFSET;
	assign v_rot  = {b_plus[ROR_SHIFT-1:0], b_plus[HASH_W-1:ROR_SHIFT]};

	assign mul_a     = (ph_q == PH_HI) ? opnd_q[HASH_W-1:HALF_W] : opnd_q[HALF_W-1:0];
	assign mul_b     = (ph_q == PH_CROSS) ? MUL_HI : MUL_LO;
	assign mul_p     = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
	assign prod_full = {hi_acc_q + mul_p[HALF_W-1:0], prod_lo_q[HALF_W-1:0]};
	assign prod_mix  = prod_full ^ (prod_full >> HASH_SHIFT);

	always_comb begin
		state_d = state_q;
		in_rdy  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (s_axis_tvalid && emit) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (rnd_q == RND_FINAL && ph_q == PH_CROSS) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ph_q        <= PH_LO;
			rnd_q       <= RND_FIRST;
			auto_dump_q <= 1'b0;
			last_vld_q  <= 1'b0;
			last_tile_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) auto_dump_q <= cfg_data;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (s_fire) begin
				last_vld_q  <= in_bound;
				last_tile_q <= in_tile;
			end
			if (state_q == ST_LOAD) begin
				ph_q  <= PH_LO;
				rnd_q <= RND_FIRST;
			end else if (state_q == ST_MUL) begin
				if (ph_q == PH_CROSS) begin
					ph_q  <= PH_LO;
					rnd_q <= rnd_q + 1'b1;
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
			if (state_q == ST_DONE && out_free) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem_q[clr_q] <= '0;
		else if (s_fire && in_bound) mem_q[in_tile[ROW_W-1:0]][in_lane] <= in_byte;
		if (s_fire && emit) rd_row_q <= mem_q[last_tile_q[ROW_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (s_fire && emit) pend_tile_q <= last_tile_q;
		if (state_q == ST_LOAD) begin
			opnd_q <= w_a ^ v_rot;
			v_q    <= v_rot;
			b_q    <= w_b;
		end
		if (state_q == ST_MUL) begin
			unique case (ph_q)
				PH_LO:    prod_lo_q <= mul_p;
				PH_HI:    hi_acc_q  <= prod_lo_q[HASH_W-1:HALF_W] + mul_p[HALF_W-1:0];
				PH_CROSS: begin
					unique case (rnd_q)
						RND_FIRST:  opnd_q <= v_q ^ prod_mix;
						RND_SECOND: opnd_q <= prod_mix;
						RND_FINAL:  hash_q <= prod_full ^ b_q;
						default:    hash_q <= hash_q;
					endcase
				end
				default: prod_lo_q <= prod_lo_q;
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			out_tile_q <= pend_tile_q;
			out_hash_q <= hash_q;
		end
	end

	a_emit_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && emit) |=> (state_q == ST_LOAD))
		else $error("emitting transfer did not start the hash sequence");

	a_mul_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (ph_q <= PH_CROSS && rnd_q <= RND_FINAL))
		else $error("multiply sequencer counter out of range");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

	a_out_tile_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ({1'b0, out_tile_q} < TILE_LIM))
		else $error("emitted tile index outside the mirror");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_MUL) |=> !$past(s_fire))
		else $error("input transfer accepted while hashing");

endmodule
